### hw/rtl/wch_pkg.sv
// Shared types, constants and arithmetic helpers for the weighted category histogram.
// Used by weighted_category_histogram_top; no dependencies.

package wch_pkg;

    localparam int SLOTS   = 16;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam int CMD_W   = 2;
    localparam int SLOTF_W = 4;
    localparam int KEY_W   = 32;
    localparam int WGT_W   = 32;
    localparam int ACC_W   = 48;
    localparam int FRAC_W  = 18;
    localparam int SIU_W   = 5;

    // Quotient bits of the Q1.16 fraction, one per divider step
    localparam int QBITS   = 16;
    localparam int STEP_W  = $clog2(QBITS);

    localparam int IN_FIELDS_W  = SLOTF_W + KEY_W + WGT_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 3 * ACC_W + FRAC_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

    localparam logic [ACC_W-1:0] ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [QBITS:0]   FRAC_ONE = {1'b1, {QBITS{1'b0}}};

    typedef enum logic [CMD_W-1:0] {
        CMD_DEFINE = 2'd0,
        CMD_FILL   = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_RSVD   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_MOD,
        S_PREP,
        S_DIV,
        S_PUSH
    } t_state;

    // Signed accumulate of a sign-extended weight, clamped to the accumulator range
    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                                 input logic [WGT_W-1:0] w);
        logic [ACC_W:0] s;
        s = {acc[ACC_W-1], acc} + {{(ACC_W+1-WGT_W){w[WGT_W-1]}}, w};
        if (s[ACC_W] != s[ACC_W-1]) begin
            return s[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        return s[ACC_W-1:0];
    endfunction

    // Magnitude of a two's complement value; the most negative value maps to 2^(ACC_W-1)
    function automatic logic [ACC_W-1:0] mag(input logic [ACC_W-1:0] v);
        return v[ACC_W-1] ? (~v + {{(ACC_W-1){1'b0}}, 1'b1}) : v;
    endfunction

endpackage

### hw/rtl/weighted_category_histogram_top.sv
// Each item passes S_LOOK, S_MOD and S_PREP, then goes straight to S_PUSH when no division is needed
// (define, unmatched key, zero count or total, saturated fraction), else through S_DIV first.
// Flow: one item at a time, taken once the result sits in the output register; a new item
// is not taken before the last result is pushed, and S_PUSH holds while the output register is full.
// The restoring divider (one quotient bit per cycle) sets the long case.
// Reset: synchronous active low; clears counts (slot valid bits), sums and slots_in_use.

module weighted_category_histogram_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration: slots_in_use
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [wch_pkg::SIU_W-1:0]       i_cfg_data,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [wch_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // slot, key, weight, zero pad
    input  logic [wch_pkg::CMD_W-1:0]       s_axis_tuser,  // cmd
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [wch_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // slot_count, overflow_sum,
                                                           // total_sum, fraction, zero pad
    output logic [1:0]                      m_axis_tuser   // found, empty_res
);
    import wch_pkg::*;

    // control and state
    t_state                 r_state, n_state;
    logic [SIU_W-1:0]       r_siu, n_siu;
    logic [KEY_W-1:0]       r_keys [SLOTS];
    logic [KEY_W-1:0]       n_keys [SLOTS];
    logic [SLOTS-1:0]       r_valid, n_valid;
    logic [ACC_W-1:0]       r_ovf, n_ovf;
    logic [ACC_W-1:0]       r_total, n_total;

    // count memory
    logic [ACC_W-1:0]       r_mem [SLOTS];
    logic [ACC_W-1:0]       r_rdata;
    logic                   w_mem_we;

    // item in flight
    t_cmd                   r_cmd, n_cmd;
    logic [KEY_W-1:0]       r_key, n_key;
    logic [WGT_W-1:0]       r_weight, n_weight;
    logic                   r_hit, n_hit;
    logic [SLOT_W-1:0]      r_idx, n_idx;
    logic [ACC_W-1:0]       r_cnt, n_cnt;

    // divider
    logic                   r_neg, n_neg;
    logic [ACC_W-1:0]       r_rem, n_rem;
    logic [ACC_W-1:0]       r_den, n_den;
    logic [QBITS:0]         r_quo, n_quo;
    logic [STEP_W-1:0]      r_step, n_step;

    // output register
    logic                   r_out_valid, n_out_valid;
    logic                   r_o_found, n_o_found;
    logic                   r_o_empty, n_o_empty;
    logic [ACC_W-1:0]       r_o_cnt, n_o_cnt;
    logic [ACC_W-1:0]       r_o_ovf, n_o_ovf;
    logic [ACC_W-1:0]       r_o_total, n_o_total;
    logic [FRAC_W-1:0]      r_o_frac, n_o_frac;

    // key match over slots in use
    logic [SLOTS-1:0]       w_match;
    logic [SLOT_W-1:0]      w_first;

    // read-modify-write values
    logic [ACC_W-1:0]       w_cnt_rd;
    logic [ACC_W-1:0]       w_cnt_new;
    logic                   w_fill;

    // divider datapath
    logic [ACC_W-1:0]       w_a, w_b;
    logic [ACC_W:0]         w_shift;
    logic                   w_ge;
    logic [FRAC_W-1:0]      w_quo_ext;

    logic                   w_in_xfer;
    logic                   w_out_free;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    always_comb begin
        w_first = '0;
        for (int i = 0; i < SLOTS; i++) begin
            // a slots_in_use above SLOTS leaves every slot active
            w_match[i] = (r_keys[i] == r_key) && (i < int'(r_siu));
        end
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_first = SLOT_W'(i);
            end
        end
    end

    // a slot not valid since reset or its last define reads as zero
    assign w_cnt_rd  = r_valid[r_idx] ? r_rdata : '0;
    assign w_cnt_new = sat_add(w_cnt_rd, r_weight);
    assign w_fill    = (r_cmd == CMD_FILL) && (r_weight != '0);
    assign w_mem_we  = (r_state == S_MOD) && w_fill && r_hit;

    assign w_a       = mag(r_cnt);
    assign w_b       = mag(r_total);
    assign w_shift   = {r_rem, 1'b0};
    assign w_ge      = w_shift >= {1'b0, r_den};
    assign w_quo_ext = {{(FRAC_W-QBITS-1){1'b0}}, r_quo};

    always_comb begin
        n_state     = r_state;
        n_siu       = r_siu;
        n_keys      = r_keys;
        n_valid     = r_valid;
        n_ovf       = r_ovf;
        n_total     = r_total;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_weight    = r_weight;
        n_hit       = r_hit;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_neg       = r_neg;
        n_rem       = r_rem;
        n_den       = r_den;
        n_quo       = r_quo;
        n_step      = r_step;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_o_found   = r_o_found;
        n_o_empty   = r_o_empty;
        n_o_cnt     = r_o_cnt;
        n_o_ovf     = r_o_ovf;
        n_o_total   = r_o_total;
        n_o_frac    = r_o_frac;

        if (i_cfg_valid) begin
            n_siu = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_cmd    = t_cmd'(s_axis_tuser);
                    n_key    = s_axis_tdata[SLOTF_W +: KEY_W];
                    n_weight = s_axis_tdata[SLOTF_W + KEY_W +: WGT_W];
                    // define: write the key now, drop the count by clearing valid
                    if (t_cmd'(s_axis_tuser) == CMD_DEFINE) begin
                        for (int i = 0; i < SLOTS; i++) begin
                            if (int'(s_axis_tdata[SLOTF_W-1:0]) == i) begin
                                n_keys[i]  = s_axis_tdata[SLOTF_W +: KEY_W];
                                n_valid[i] = 1'b0;
                            end
                        end
                    end
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_hit   = |w_match;
                n_idx   = w_first;
                n_state = S_MOD;
            end
            S_MOD: begin
                if (w_fill) begin
                    n_total = sat_add(r_total, r_weight);
                    if (r_hit) begin
                        n_valid[r_idx] = 1'b1;
                    end else begin
                        n_ovf = sat_add(r_ovf, r_weight);
                    end
                end
                if (!r_hit) begin
                    n_cnt = '0;
                end else if (w_fill) begin
                    n_cnt = w_cnt_new;
                end else begin
                    n_cnt = w_cnt_rd;
                end
                n_state = S_PREP;
            end
            S_PREP: begin
                n_neg = r_cnt[ACC_W-1] ^ r_total[ACC_W-1];
                priority if (w_a == '0 || w_b == '0) begin
                    n_quo   = '0;
                    n_state = S_PUSH;
                end else if (w_a >= w_b) begin
                    n_quo   = FRAC_ONE;
                    n_state = S_PUSH;
                end else begin
                    n_rem   = w_a;
                    n_den   = w_b;
                    n_quo   = '0;
                    n_step  = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // restoring step: one quotient bit per cycle
                n_rem  = w_ge ? (w_shift[ACC_W-1:0] - r_den) : w_shift[ACC_W-1:0];
                n_quo  = {r_quo[QBITS-1:0], w_ge};
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(QBITS - 1)) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                // hold until the output register is free or drains this cycle
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_o_found   = r_hit;
                    n_o_empty   = (r_total == '0);
                    n_o_cnt     = r_cnt;
                    n_o_ovf     = r_ovf;
                    n_o_total   = r_total;
                    n_o_frac    = r_neg ? (~w_quo_ext + {{(FRAC_W-1){1'b0}}, 1'b1})
                                        : w_quo_ext;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_siu       <= '0;
            r_valid     <= '0;
            r_ovf       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_siu       <= n_siu;
            r_valid     <= n_valid;
            r_ovf       <= n_ovf;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_keys    <= n_keys;
        r_cmd     <= n_cmd;
        r_key     <= n_key;
        r_weight  <= n_weight;
        r_hit     <= n_hit;
        r_idx     <= n_idx;
        r_cnt     <= n_cnt;
        r_neg     <= n_neg;
        r_rem     <= n_rem;
        r_den     <= n_den;
        r_quo     <= n_quo;
        r_step    <= n_step;
        r_o_found <= n_o_found;
        r_o_empty <= n_o_empty;
        r_o_cnt   <= n_o_cnt;
        r_o_ovf   <= n_o_ovf;
        r_o_total <= n_o_total;
        r_o_frac  <= n_o_frac;
    end

    // count memory: read issued in S_LOOK, data used in S_MOD, write-back in S_MOD
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_idx] <= w_cnt_new;
        end
        r_rdata <= r_mem[n_idx];
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_o_frac, r_o_total, r_o_ovf, r_o_cnt};
    assign m_axis_tuser  = {r_o_empty, r_o_found};

    a_rmw_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == S_LOOK) ##1 (r_state == S_MOD))
        else $error("item did not pass lookup and read-modify-write in order");

    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    a_quo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH) |-> (r_quo <= FRAC_ONE))
        else $error("fraction magnitude above one");

    a_empty_frac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_empty) |-> (r_o_frac == '0))
        else $error("empty total with nonzero fraction");

    a_unfound_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_o_found) |-> (r_o_cnt == '0 && r_o_frac == '0))
        else $error("unmatched key with nonzero count or fraction");

endmodule
